[rtl/core/bpu_pkg.sv]
package bpu_pkg;

   // Widths fixed by the register map and the result word.
   localparam int SIZE_W   = 13;
   localparam int COORD_W  = 12;
   localparam int BYTE_W   = 8;
   localparam int MASK_W   = 32;
   localparam int INDEX_W  = 3;
   localparam int SIZE_FIELD_MAX = (1 << SIZE_W) - 1;

   // Default image size limits for the top level.
   localparam int MAX_WIDTH_DEF  = 4096;
   localparam int MAX_HEIGHT_DEF = 4096;

   // Depth of the pixel queue between the front and back parts; a power of two.
   localparam int QUEUE_DEPTH = 4;

   // Register reset values.
   localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(1);
   localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(1);
   localparam logic [1:0]        ORIENT_RESET = 2'd0;
   localparam logic              FORMAT_RESET = 1'b1;
   localparam logic [MASK_W-1:0] RED_RESET    = 32'h00FF_0000;
   localparam logic [MASK_W-1:0] GREEN_RESET  = 32'h0000_FF00;
   localparam logic [MASK_W-1:0] BLUE_RESET   = 32'h0000_00FF;
   localparam logic [MASK_W-1:0] ALPHA_RESET  = 32'hFF00_0000;

   // Alpha value reported for 24-bit pixels.
   localparam logic [BYTE_W-1:0] ALPHA_OPAQUE = 8'hFF;

   typedef enum logic [INDEX_W-1:0] {
      REG_IMAGE_WIDTH  = 3'd0,
      REG_IMAGE_HEIGHT = 3'd1,
      REG_ORIENTATION  = 3'd2,
      REG_PIXEL_FORMAT = 3'd3,
      REG_RED_MASK     = 3'd4,
      REG_GREEN_MASK   = 3'd5,
      REG_BLUE_MASK    = 3'd6,
      REG_ALPHA_MASK   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [SIZE_W-1:0] width;
      logic [SIZE_W-1:0] height;
      logic [1:0]        orientation;
      logic              pixel_format;
   } geom_type;

   typedef struct packed {
      logic [MASK_W-1:0] red;
      logic [MASK_W-1:0] green;
      logic [MASK_W-1:0] blue;
      logic [MASK_W-1:0] alpha;
   } mask_type;

   typedef struct packed {
      logic [MASK_W-1:0]  word;
      logic [COORD_W-1:0] col_x;
      logic [COORD_W-1:0] row_y;
      logic               last_pixel;
      logic               wide;
   } pix_type;

   typedef struct packed {
      logic push;
      logic pad_busy;
   } front_status_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

[rtl/core/bpu_front.sv]
module bpu_front #(
   parameter int MAX_WIDTH  = bpu_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bpu_pkg::MAX_HEIGHT_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             accept,
   input  logic [bpu_pkg::BYTE_W-1:0]       pixel_byte,
   input  bpu_pkg::geom_type                geom,
   output bpu_pkg::pix_type                 pix,
   output bpu_pkg::front_status_type        status
);

   localparam int W_CAP = (MAX_WIDTH > bpu_pkg::SIZE_FIELD_MAX) ?
                          bpu_pkg::SIZE_FIELD_MAX : MAX_WIDTH;
   localparam int H_CAP = (MAX_HEIGHT > bpu_pkg::SIZE_FIELD_MAX) ?
                          bpu_pkg::SIZE_FIELD_MAX : MAX_HEIGHT;
   localparam int CW = (W_CAP > 1) ? $clog2(W_CAP) : 1;
   localparam int RW = (H_CAP > 1) ? $clog2(H_CAP) : 1;
   localparam logic [bpu_pkg::SIZE_W-1:0] W_CAP_V = bpu_pkg::SIZE_W'(W_CAP);
   localparam logic [bpu_pkg::SIZE_W-1:0] H_CAP_V = bpu_pkg::SIZE_W'(H_CAP);
   localparam logic [bpu_pkg::SIZE_W-1:0] ONE     = bpu_pkg::SIZE_W'(1);

   logic [1:0]    slot_ff, slot_in;
   logic [23:0]   held_ff, held_in;
   logic [CW-1:0] col_ff, col_in;
   logic [RW-1:0] row_ff, row_in;
   logic [1:0]    pad_ff, pad_in;

   logic [bpu_pkg::SIZE_W-1:0] w, h, wm1, hm1, col_ext, row_ext, fc, fr, x_full, y_full;
   logic [23:0] merged;
   logic [bpu_pkg::BYTE_W-1:0] top_byte;
   logic complete, row_end, img_end, pad_busy;

   // Effective size: zero acts as one, and the size saturates at the limit.
   always_comb begin
      w = (geom.width == '0) ? ONE : ((geom.width > W_CAP_V) ? W_CAP_V : geom.width);
      h = (geom.height == '0) ? ONE : ((geom.height > H_CAP_V) ? H_CAP_V : geom.height);
      wm1 = w - ONE;
      hm1 = h - ONE;
      col_ext = bpu_pkg::SIZE_W'(col_ff);
      row_ext = bpu_pkg::SIZE_W'(row_ff);
      fc = (col_ext < wm1) ? col_ext : wm1;
      fr = (row_ext < hm1) ? row_ext : hm1;
      row_end = (fc == wm1);
      img_end = row_end && (fr == hm1);
      x_full = geom.orientation[0] ? (wm1 - fc) : fc;
      y_full = geom.orientation[1] ? fr : (hm1 - fr);
   end

   // Insert the arriving byte at its slot; a fourth byte counts only in 32-bit mode.
   always_comb begin
      merged = held_ff;
      case (slot_ff)
         2'd0: begin
            merged[7:0] = pixel_byte;
         end
         2'd1: begin
            merged[15:8] = pixel_byte;
         end
         2'd2: begin
            merged[23:16] = pixel_byte;
         end
         default: begin
            merged = held_ff;
         end
      endcase
      top_byte = (slot_ff == 2'd3 && geom.pixel_format) ? pixel_byte : '0;
      complete = geom.pixel_format ? (slot_ff == 2'd3) : (slot_ff >= 2'd2);
      pad_busy = (pad_ff != 2'd0);
   end

   always_comb begin
      slot_in = slot_ff;
      held_in = held_ff;
      col_in  = col_ff;
      row_in  = row_ff;
      pad_in  = pad_ff;
      if (accept) begin
         if (pad_busy) begin
            pad_in = pad_ff - 2'd1;
         end else if (!complete) begin
            held_in = merged;
            slot_in = slot_ff + 2'd1;
         end else begin
            slot_in = 2'd0;
            if (row_end) begin
               col_in = '0;
               // Rows of 24-bit pixels pad up to a multiple of four bytes.
               pad_in = geom.pixel_format ? 2'd0 : w[1:0];
               row_in = img_end ? '0 : RW'(fr + ONE);
            end else begin
               col_in = CW'(fc + ONE);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         col_ff  <= '0;
         row_ff  <= '0;
         pad_ff  <= '0;
      end else begin
         slot_ff <= slot_in;
         col_ff  <= col_in;
         row_ff  <= row_in;
         pad_ff  <= pad_in;
      end
   end

   always_ff @(posedge clock) begin
      held_ff <= held_in;
   end

   always_comb begin
      pix.word       = {top_byte, merged};
      pix.col_x      = x_full[bpu_pkg::COORD_W-1:0];
      pix.row_y      = y_full[bpu_pkg::COORD_W-1:0];
      pix.last_pixel = img_end;
      pix.wide       = geom.pixel_format;
      status.push     = accept && !pad_busy && complete;
      status.pad_busy = pad_busy;
   end

endmodule

[rtl/core/bpu_queue.sv]
module bpu_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  bpu_pkg::pix_type           pix_in,
   input  logic                       pop,
   output bpu_pkg::pix_type           pix_out,
   output bpu_pkg::queue_status_type  status
);

   localparam int DEPTH = bpu_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);

   bpu_pkg::pix_type entry_ff [DEPTH];

   logic [PW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [PW:0]   count_ff, count_in;

   always_comb begin
      wr_in    = push ? wr_ff + PW'(1) : wr_ff;
      rd_in    = pop ? rd_ff + PW'(1) : rd_ff;
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ff] <= pix_in;
      end
   end

   always_comb begin
      pix_out      = entry_ff[rd_ff];
      status.full  = (count_ff == (PW+1)'(DEPTH));
      status.empty = (count_ff == '0);
   end

endmodule

[rtl/core/bpu_back.sv]
module bpu_back (
   input  logic                              clock,
   input  logic                              reset,
   input  bpu_pkg::pix_type                  pix,
   input  bpu_pkg::queue_status_type         queue_status,
   input  bpu_pkg::mask_type                 masks,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bpu_pkg::COORD_W-1:0]       rsp_col_x,
   output logic [bpu_pkg::COORD_W-1:0]       rsp_row_y,
   output logic [bpu_pkg::BYTE_W-1:0]        rsp_red,
   output logic [bpu_pkg::BYTE_W-1:0]        rsp_green,
   output logic [bpu_pkg::BYTE_W-1:0]        rsp_blue,
   output logic [bpu_pkg::BYTE_W-1:0]        rsp_alpha,
   output logic                              rsp_last_pixel
);

   // Each pixel byte is ANDed with the matching mask byte, and the four are summed mod 256.
   function automatic logic [bpu_pkg::BYTE_W-1:0] channel_sum(
      input logic [bpu_pkg::MASK_W-1:0] word,
      input logic [bpu_pkg::MASK_W-1:0] mask
   );
      logic [bpu_pkg::MASK_W-1:0] both;
      both = word & mask;
      return both[7:0] + both[15:8] + both[23:16] + both[31:24];
   endfunction

   logic valid_ff, valid_in;
   logic [bpu_pkg::COORD_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [bpu_pkg::BYTE_W-1:0]  red_ff, red_in, green_ff, green_in;
   logic [bpu_pkg::BYTE_W-1:0]  blue_ff, blue_in, alpha_ff, alpha_in;
   logic last_ff, last_in;

   always_comb begin
      pop      = !queue_status.empty && (!valid_ff || !rsp_stall);
      valid_in = pop || (valid_ff && rsp_stall);
      col_in   = pix.col_x;
      row_in   = pix.row_y;
      red_in   = channel_sum(pix.word, masks.red);
      green_in = channel_sum(pix.word, masks.green);
      blue_in  = channel_sum(pix.word, masks.blue);
      alpha_in = pix.wide ? channel_sum(pix.word, masks.alpha) : bpu_pkg::ALPHA_OPAQUE;
      last_in  = pix.last_pixel;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         red_ff   <= red_in;
         green_ff <= green_in;
         blue_ff  <= blue_in;
         alpha_ff <= alpha_in;
         last_ff  <= last_in;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_col_x      = col_ff;
   assign rsp_row_y      = row_ff;
   assign rsp_red        = red_ff;
   assign rsp_green      = green_ff;
   assign rsp_blue       = blue_ff;
   assign rsp_alpha      = alpha_ff;
   assign rsp_last_pixel = last_ff;

endmodule

[rtl/core/bmp_pixel_unpacker.sv]
// Pixel array decoder for BMP images. Bytes of the pixel array enter on the req_ channel
// in file order, one byte per clock while req_stall is low; every third (24-bit) or fourth
// (32-bit) byte completes a pixel, and the padding at the end of each file row is
// dropped without a result. Each pixel leaves on the rsp_ channel with its image
// coordinates, the masked channel sums (alpha is FF for 24-bit pixels) and a flag on the
// final pixel of the image. The front part updates its byte, column and row counts as each
// byte is accepted, so a byte is taken on every clock that req_stall is low; a completed
// pixel is written into a four-word queue and moves into the output register when the back
// part pops it. req_stall rises only when that queue is full, which happens only after the
// consumer has held rsp_stall. Configuration is written through the csr_ port, which is
// always ready; write it only while no word is in flight.

module bmp_pixel_unpacker #(
   parameter int MAX_WIDTH  = bpu_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = bpu_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,

   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [bpu_pkg::BYTE_W-1:0]        req_pixel_byte,

   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [bpu_pkg::COORD_W-1:0]       rsp_col_x,
   output logic [bpu_pkg::COORD_W-1:0]       rsp_row_y,
   output logic [bpu_pkg::BYTE_W-1:0]        rsp_red,
   output logic [bpu_pkg::BYTE_W-1:0]        rsp_green,
   output logic [bpu_pkg::BYTE_W-1:0]        rsp_blue,
   output logic [bpu_pkg::BYTE_W-1:0]        rsp_alpha,
   output logic                              rsp_last_pixel,

   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [bpu_pkg::INDEX_W-1:0]       csr_index,
   input  logic [bpu_pkg::MASK_W-1:0]        csr_data
);

   bpu_pkg::geom_type         geom_ff, geom_in;
   bpu_pkg::mask_type         mask_ff, mask_in;
   bpu_pkg::pix_type          front_pix, queue_pix;
   bpu_pkg::front_status_type front_status;
   bpu_pkg::queue_status_type queue_status;
   logic                      accept, pop;

   // The register file accepts a write on every clock.
   assign csr_ready = 1'b1;

   always_comb begin
      geom_in = geom_ff;
      mask_in = mask_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            bpu_pkg::REG_IMAGE_WIDTH: begin
               geom_in.width = csr_data[bpu_pkg::SIZE_W-1:0];
            end
            bpu_pkg::REG_IMAGE_HEIGHT: begin
               geom_in.height = csr_data[bpu_pkg::SIZE_W-1:0];
            end
            bpu_pkg::REG_ORIENTATION: begin
               geom_in.orientation = csr_data[1:0];
            end
            bpu_pkg::REG_PIXEL_FORMAT: begin
               geom_in.pixel_format = csr_data[0];
            end
            bpu_pkg::REG_RED_MASK: begin
               mask_in.red = csr_data;
            end
            bpu_pkg::REG_GREEN_MASK: begin
               mask_in.green = csr_data;
            end
            bpu_pkg::REG_BLUE_MASK: begin
               mask_in.blue = csr_data;
            end
            bpu_pkg::REG_ALPHA_MASK: begin
               mask_in.alpha = csr_data;
            end
            default: begin
               geom_in = geom_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         geom_ff.width        <= bpu_pkg::WIDTH_RESET;
         geom_ff.height       <= bpu_pkg::HEIGHT_RESET;
         geom_ff.orientation  <= bpu_pkg::ORIENT_RESET;
         geom_ff.pixel_format <= bpu_pkg::FORMAT_RESET;
         mask_ff.red          <= bpu_pkg::RED_RESET;
         mask_ff.green        <= bpu_pkg::GREEN_RESET;
         mask_ff.blue         <= bpu_pkg::BLUE_RESET;
         mask_ff.alpha        <= bpu_pkg::ALPHA_RESET;
      end else begin
         geom_ff <= geom_in;
         mask_ff <= mask_in;
      end
   end

   // A byte is refused only while the pixel queue has no free slot.
   assign req_stall = queue_status.full;
   assign accept    = req_valid && !req_stall;

   bpu_front #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .pixel_byte (req_pixel_byte),
      .geom       (geom_ff),
      .pix        (front_pix),
      .status     (front_status)
   );

   bpu_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (front_status.push),
      .pix_in  (front_pix),
      .pop     (pop),
      .pix_out (queue_pix),
      .status  (queue_status)
   );

   bpu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .pix            (queue_pix),
      .queue_status   (queue_status),
      .masks          (mask_ff),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_col_x      (rsp_col_x),
      .rsp_row_y      (rsp_row_y),
      .rsp_red        (rsp_red),
      .rsp_green      (rsp_green),
      .rsp_blue       (rsp_blue),
      .rsp_alpha      (rsp_alpha),
      .rsp_last_pixel (rsp_last_pixel)
   );

   // A pixel must never be written into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      !(front_status.push && queue_status.full))
      else $error("pixel pushed into a full queue");

   // The back part must never take a pixel from an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      !(pop && queue_status.empty))
      else $error("pixel taken from an empty queue");

   // A padding byte is discarded and never completes a pixel.
   assert property (@(posedge clock) disable iff (reset)
      (accept && front_status.pad_busy) |-> !front_status.push)
      else $error("padding byte produced a pixel");

endmodule
